@@ rtl/dual_ended_stack_pair_assert.svh @@
// assertion macros for the dual ended stack pair checker
// no dependencies; expects a clock and reset signal in the using scope
`ifndef DUAL_ENDED_STACK_PAIR_ASSERT_SVH
`define DUAL_ENDED_STACK_PAIR_ASSERT_SVH

// same-cycle implication
`define DESP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DESP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/desp_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the dual ended stack pair
// no dependencies
package desp_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMD_W    = 3;
   localparam int DATA_W   = 32;
   localparam int STS_W    = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_LOW  = 3'd0,
      CMD_PUSH_HIGH = 3'd1,
      CMD_POP_LOW   = 3'd2,
      CMD_POP_HIGH  = 3'd3,
      CMD_PEEK_LOW  = 3'd4,
      CMD_PEEK_HIGH = 3'd5
   } cmd_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK       = 2'd0,
      STS_OVERFLOW = 2'd1,
      STS_EMPTY    = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

@@ rtl/desp_req_if.sv @@
`timescale 1ns / 1ps
// request and response channel interfaces
// depends on desp_pkg
interface desp_req_if;
   import desp_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, command, value, input ready);
   modport sink   (input valid, command, value, output ready);
endinterface

interface desp_rsp_if;
   import desp_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] data;
   logic [STS_W-1:0]         status;

   modport source (output valid, data, status, input ready);
   modport sink   (input valid, data, status, output ready);
endinterface

@@ rtl/desp_ctrl.sv @@
`timescale 1ns / 1ps
// controller state machine: accepts a request, then commits it to the datapath
// depends on desp_pkg
module desp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  desp_pkg::stat_type stat,
   output desp_pkg::ctrl_type ctrl
);
   import desp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      ctrl.capture = 1'b0;
      ctrl.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = !reset;
            ctrl.capture = req_valid && !reset;
         end
         ST_EXEC: begin
            ctrl.commit = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ rtl/desp_datapath.sv @@
`timescale 1ns / 1ps
// datapath: shared entry store, stack counts and response register
// depends on desp_pkg
module desp_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [desp_pkg::CMD_W-1:0]         req_command,
   input  logic signed [desp_pkg::DATA_W-1:0] req_value,
   input  desp_pkg::ctrl_type                 ctrl,
   output desp_pkg::stat_type                 stat,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [desp_pkg::DATA_W-1:0] rsp_data,
   output logic [desp_pkg::STS_W-1:0]         rsp_status
);
   import desp_pkg::*;

   logic [DATA_W-1:0] mem [CAPACITY];

   cmd_type           cmd_ff;
   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic [CNT_W-1:0]  low_count_ff, low_count_in;
   logic [CNT_W-1:0]  high_count_ff, high_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  wr_addr;
   logic              wr_en;
   logic              full;
   logic [CNT_W-1:0]  top_count;

   // top entry of the addressed stack
   assign rd_addr = req_command[0] ? IDX_W'(CNT_W'(CAPACITY) - high_count_ff)
                                   : IDX_W'(low_count_ff - CNT_W'(1));
   // next free entry of the addressed stack
   assign wr_addr = cmd_ff[0] ? IDX_W'(CNT_W'(CAPACITY - 1) - high_count_ff)
                              : IDX_W'(low_count_ff);
   assign full = ({1'b0, low_count_ff} + {1'b0, high_count_ff}) >= (CNT_W + 1)'(CAPACITY);
   assign top_count = cmd_ff[0] ? high_count_ff : low_count_ff;

   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff     <= cmd_type'(req_command);
         value_ff   <= req_value;
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= value_ff;
      end
   end

   always_comb begin
      low_count_in  = low_count_ff;
      high_count_in = high_count_ff;
      rsp_data_in   = '0;
      rsp_status_in = STS_OK;
      wr_en         = 1'b0;
      case (cmd_ff) inside
         CMD_PUSH_LOW, CMD_PUSH_HIGH: begin
            if (full) begin
               rsp_status_in = STS_OVERFLOW;
            end else begin
               wr_en = ctrl.commit;
               if (cmd_ff[0]) high_count_in = high_count_ff + CNT_W'(1);
               else           low_count_in  = low_count_ff + CNT_W'(1);
            end
         end
         CMD_POP_LOW, CMD_POP_HIGH, CMD_PEEK_LOW, CMD_PEEK_HIGH: begin
            if (top_count == '0) begin
               rsp_status_in = STS_EMPTY;
            end else begin
               rsp_data_in = rd_data_ff;
               if (cmd_ff == CMD_POP_HIGH)     high_count_in = high_count_ff - CNT_W'(1);
               else if (cmd_ff == CMD_POP_LOW) low_count_in  = low_count_ff - CNT_W'(1);
            end
         end
         default: begin
            rsp_status_in = STS_OK;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.commit)    rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_count_ff  <= '0;
         high_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.commit) begin
            low_count_ff  <= low_count_in;
            high_count_ff <= high_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;

endmodule

@@ rtl/dual_ended_stack_pair.sv @@
`timescale 1ns / 1ps
// two stacks sharing one 16-entry word store, low grows up, high grows down
// usage:
//   req_ch carries command (push, pop or peek on either stack) and value
//   rsp_ch returns one response per request: data and status
//   (ok, overflow on a push into a full store, empty on pop or peek)
// timing:
//   a request is taken in the idle cycle, the store is read in that cycle,
//   and the commit state then commits counts, write and response register
//   once the response register is free; response valid is set by the commit
//   a new request is taken only after the last one commits, as the registered
//   read of the store is followed by the commit state
// reset clears both stack counts and the response valid; the store keeps
// its contents, which never reach a response before being pushed
// if the receiver stalls, the response holds in its register, one more
// request is taken and waits in the commit cycle until the register frees
// depends on desp_pkg, desp_req_if, desp_rsp_if, desp_ctrl, desp_datapath
module dual_ended_stack_pair (
   input  logic       clock,
   input  logic       reset,
   desp_req_if.sink   req_ch,
   desp_rsp_if.source rsp_ch
);
   import desp_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   desp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   desp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_command (req_ch.command),
      .req_value   (req_ch.value),
      .ctrl        (ctrl),
      .stat        (stat),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_data    (rsp_ch.data),
      .rsp_status  (rsp_ch.status)
   );

endmodule

@@ rtl/desp_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for dual_ended_stack_pair, bound to the top level
// depends on desp_pkg and dual_ended_stack_pair_assert.svh
`include "dual_ended_stack_pair_assert.svh"

module desp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [desp_pkg::DATA_W-1:0] rsp_data,
   input logic [desp_pkg::STS_W-1:0]         rsp_status
);
   import desp_pkg::*;

   `DESP_ASSERT_NOW(a_err_data_zero, rsp_valid && (rsp_status != STS_OK), rsp_data == '0, "error response with nonzero data")
   `DESP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data) && $stable(rsp_status), "stalled response changed")
   `DESP_ASSERT_NOW(a_req_answered, req_valid && req_ready, ##2 rsp_valid, "no response two cycles after request")
   `DESP_ASSERT_NOW(a_reset_quiet, $past(reset), !rsp_valid, "response valid right after reset")

endmodule

bind dual_ended_stack_pair desp_checker u_desp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_data   (rsp_ch.data),
   .rsp_status (rsp_ch.status)
);

@@ tb/tb_dual_ended_stack_pair.sv @@
`timescale 1ns / 1ps
// testbench for dual_ended_stack_pair: directed and random push, pop and peek requests
// checked against a predictor of both stacks; depends on desp_pkg, desp_req_if, desp_rsp_if
module tb_dual_ended_stack_pair;
   import desp_pkg::*;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      status_type               status;
   } stack_result_type;

   localparam int HOLD_CYCLES    = 80;
   localparam int MAX_REPORTS    = 10;
   localparam int DRAIN_LIMIT    = 4000;
   localparam int SETTLE_CYCLES  = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   desp_req_if req_ch ();
   desp_rsp_if rsp_ch ();

   dual_ended_stack_pair i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predictor state
   logic signed [DATA_W-1:0] word_mirror [CAPACITY];
   int                       low_depth  = 0;
   int                       high_depth = 0;
   stack_result_type         pending_results[$];

   int mismatch_count = 0;
   int gap_max        = 0;
   int burst_left     = 0;
   int stall_pct      = 0;
   int hold_left      = 0;
   bit hold_request   = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #2ms;
      $display("simulation failed");
      $finish;
   end

   function automatic stack_result_type stack_pair_predict(cmd_type cmd,
                                                           logic signed [DATA_W-1:0] value);
      stack_result_type res;
      res.data   = '0;
      res.status = STS_OK;
      case (cmd)
         CMD_PUSH_LOW, CMD_PUSH_HIGH: begin
            if (low_depth + high_depth >= CAPACITY) begin
               res.status = STS_OVERFLOW;
            end else if (cmd == CMD_PUSH_LOW) begin
               word_mirror[low_depth] = value;
               low_depth++;
            end else begin
               high_depth++;
               word_mirror[CAPACITY - high_depth] = value;
            end
         end
         CMD_POP_LOW, CMD_PEEK_LOW: begin
            if (low_depth == 0) begin
               res.status = STS_EMPTY;
            end else begin
               res.data = word_mirror[low_depth - 1];
               if (cmd == CMD_POP_LOW) low_depth--;
            end
         end
         CMD_POP_HIGH, CMD_PEEK_HIGH: begin
            if (high_depth == 0) begin
               res.status = STS_EMPTY;
            end else begin
               res.data = word_mirror[CAPACITY - high_depth];
               if (cmd == CMD_POP_HIGH) high_depth--;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // one request, then burst pacing on the sender side
   task automatic send_request(input cmd_type cmd, input logic signed [DATA_W-1:0] value);
      int gap;
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.value   <= value;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(stack_pair_predict(cmd, value));
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic logic signed [DATA_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   function automatic cmd_type random_command(int push_pct);
      int pick;
      bit high;
      pick = $urandom_range(0, 99);
      high = $urandom_range(0, 1);
      if (pick < push_pct) return high ? CMD_PUSH_HIGH : CMD_PUSH_LOW;
      if (pick < push_pct + (100 - push_pct) * 2 / 3) return high ? CMD_POP_HIGH : CMD_POP_LOW;
      return high ? CMD_PEEK_HIGH : CMD_PEEK_LOW;
   endfunction

   task automatic test_empty_stacks();
      send_request(CMD_POP_LOW, 32'sh1234_5678);
      send_request(CMD_POP_HIGH, -1);
      send_request(CMD_PEEK_LOW, 32'sh7fff_ffff);
      send_request(CMD_PEEK_HIGH, 32'sh8000_0000);
   endtask

   task automatic test_full_store();
      logic signed [DATA_W-1:0] fill_words [4];
      fill_words = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh5555_5555, 32'shaaaa_aaaa};
      for (int i = 0; i < CAPACITY; i++)
         send_request(i[0] ? CMD_PUSH_HIGH : CMD_PUSH_LOW, fill_words[i % 4] ^ i);
      send_request(CMD_PUSH_LOW, 32'sh0bad_0bad);
      send_request(CMD_PUSH_HIGH, -1);
      send_request(CMD_PEEK_LOW, '0);
      send_request(CMD_PEEK_HIGH, '0);
      send_request(CMD_POP_LOW, '0);
      send_request(CMD_POP_HIGH, '0);
   endtask

   task automatic test_random_traffic(int count, int push_pct, int stall, int gap);
      stall_pct = stall;
      gap_max   = gap;
      repeat (count) send_request(random_command(push_pct), random_word());
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_backpressure();
      stall_pct = 0;
      gap_max   = 0;
      hold_request <= 1'b1;
      repeat (24) send_request(random_command(50), random_word());
   endtask

   // receiver side: random stall rate per phase plus a long hold on request
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_request) begin
            hold_request <= 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      stack_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("unexpected response: data %h status %0d", rsp_ch.data, rsp_ch.status);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.data !== want.data || rsp_ch.status !== want.status) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("response mismatch: expected data %h status %0d, got data %h status %0d",
                           want.data, want.status, rsp_ch.data, rsp_ch.status);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int waited;
      req_ch.valid   = 1'b0;
      req_ch.command = CMD_PUSH_LOW;
      req_ch.value   = '0;
      rsp_ch.ready   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_stacks();
      test_full_store();
      test_random_traffic(120, 70, 0, 0);
      test_random_traffic(150, 30, 20, 4);
      test_backpressure();
      test_random_traffic(150, 50, 50, 8);
      test_random_traffic(130, 75, 10, 2);
      test_random_traffic(150, 25, 35, 3);
      req_ch.valid <= 1'b0;

      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0d responses never arrived", pending_results.size());
         mismatch_count++;
      end

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/desp_pkg.sv
rtl/desp_req_if.sv
rtl/desp_ctrl.sv
rtl/desp_datapath.sv
rtl/dual_ended_stack_pair.sv
rtl/desp_checker.sv
tb/tb_dual_ended_stack_pair.sv
